// File: hw/rtl/spq_pkg.sv
// Package for the sorted priority queue core.
// Holds the transfer structs, mode and status codes and the priority compare.
// No dependencies.
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        [1:0]  mode;
    logic signed [31:0] data_in;
    logic signed [31:0] priority_in;
  } spq_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] data_out;
    logic signed [31:0] priority_out;
    logic               is_empty;
    logic signed [31:0] top_priority;
    logic        [5:0]  entry_count;
  } spq_out_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t new_entry;
  } spq_ctrl_t;

  function automatic logic prio_gt(input logic signed [31:0] a, input logic signed [31:0] b);
    return a > b;
  endfunction

endpackage

// File: hw/rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue core: a row of spq_cell slots
// plus the entry count and result register. Depends on spq_pkg, spq_cell.
//
// Usage:
//   Commands arrive on in_item and transfer at a rising edge with start high
//   and busy low. busy is always low: every slot compares the new priority
//   with its own and keeps, loads or shifts in the same cycle, so a command
//   may follow every cycle.
//   Each command yields one result on out_item, marked by out_valid for
//   exactly one cycle, the cycle after the command transfer.
//   The receiver cannot stall; results must be taken when shown.
//   Status reports a dropped insert on a full queue and a remove on an
//   empty queue; both leave the queue unchanged.
//   Reset (rst_n low, synchronous) empties the queue and clears out_valid;
//   slot contents are left as they are and only slots below the count
//   are ever read.
//   Depth is set by DEPTH (2 to 256); entry_count gives the low 6 bits of
//   the count.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_item,
  output logic     out_valid,
  output spq_out_t out_item
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  spq_out_t      out_r, out_nxt;

  spq_ctrl_t  ctrl;
  spq_entry_t ent   [DEPTH];
  logic       keeps [DEPTH];
  logic       accept;
  logic       full;
  logic       empty;
  logic       gt0;
  logic signed [31:0] top_post;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign gt0    = prio_gt(in_item.priority_in, ent[0].prio);

  assign ctrl.ins = accept && (in_item.mode == MODE_INSERT) && !full;
  assign ctrl.rem = accept && (in_item.mode == MODE_REMOVE) && !empty;
  assign ctrl.new_entry.data = in_item.data_in;
  assign ctrl.new_entry.prio = in_item.priority_in;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cnt_r > CW'(i)),
      .left_keep   ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .left_entry  (ent[(i == 0) ? 0 : i - 1]),
      .right_entry (ent[(i == DEPTH - 1) ? i : i + 1]),
      .keep        (keeps[i]),
      .entry       (ent[i])
    );
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    top_post = empty ? 32'sd0 : ent[0].prio;
    out_nxt  = '0;
    out_nxt.status = STATUS_DONE;
    case (in_item.mode)
      MODE_INSERT: begin
        if (full) begin
          out_nxt.status = STATUS_FULL;
        end else begin
          cnt_nxt  = cnt_r + CW'(1);
          top_post = (empty || gt0) ? in_item.priority_in : ent[0].prio;
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          out_nxt.status = STATUS_EMPTY;
        end else begin
          cnt_nxt              = cnt_r - CW'(1);
          out_nxt.data_out     = ent[0].data;
          out_nxt.priority_out = ent[0].prio;
          top_post = (cnt_r > CW'(1)) ? ent[1].prio : 32'sd0;
        end
      end
      default: begin
      end
    endcase
    out_nxt.is_empty     = (cnt_nxt == '0);
    out_nxt.top_priority = top_post;
    out_nxt.entry_count  = 6'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// File: hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry, decides keep/load/shift.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  spq_ctrl_t  ctrl,
  input  logic       occupied,
  input  logic       left_keep,
  input  spq_entry_t left_entry,
  input  spq_entry_t right_entry,
  output logic       keep,
  output spq_entry_t entry
);

  spq_entry_t entry_r;
  spq_entry_t entry_nxt;

  // entry stays put when it ranks at or above the newcomer
  assign keep  = occupied && !prio_gt(ctrl.new_entry.prio, entry_r.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (keep) begin
        entry_nxt = entry_r;
      end else if (left_keep) begin
        entry_nxt = ctrl.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: tb/sv/spq_checker.sv
// Checker for sorted_priority_queue_core: follows command and result transfers,
// keeps its own sorted copy of the queue and compares each result field by field.
// Depends on spq_pkg.
module spq_checker import spq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  spq_in_t     in_item,
  input  logic        out_valid,
  input  spq_out_t    out_item,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  spq_entry_t held_entries[$];
  spq_out_t   pending_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic spq_out_t serve_command(input spq_in_t cmd);
    spq_out_t   res;
    spq_entry_t ent;
    int         pos;
    res = '0;
    res.status = STATUS_DONE;
    case (cmd.mode)
      MODE_INSERT: begin
        if (held_entries.size() >= DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          pos = held_entries.size();
          for (int i = 0; i < held_entries.size(); i++) begin
            if (cmd.priority_in > held_entries[i].prio) begin
              pos = i;
              break;
            end
          end
          ent.data = cmd.data_in;
          ent.prio = cmd.priority_in;
          held_entries.insert(pos, ent);
        end
      end
      MODE_REMOVE: begin
        if (held_entries.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          ent = held_entries.pop_front();
          res.data_out     = ent.data;
          res.priority_out = ent.prio;
        end
      end
      default: ;
    endcase
    res.is_empty     = (held_entries.size() == 0);
    res.top_priority = (held_entries.size() == 0) ? '0 : held_entries[0].prio;
    res.entry_count  = 6'(held_entries.size());
    return res;
  endfunction

  task automatic note_mismatch(input string field, input logic signed [63:0] exp_val,
                               input logic signed [63:0] act_val);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, act_val);
  endtask

  task automatic compare_result(input spq_out_t exp_res, input spq_out_t act_res);
    if (exp_res.status !== act_res.status)
      note_mismatch("status", exp_res.status, act_res.status);
    if (exp_res.data_out !== act_res.data_out)
      note_mismatch("data_out", exp_res.data_out, act_res.data_out);
    if (exp_res.priority_out !== act_res.priority_out)
      note_mismatch("priority_out", exp_res.priority_out, act_res.priority_out);
    if (exp_res.is_empty !== act_res.is_empty)
      note_mismatch("is_empty", exp_res.is_empty, act_res.is_empty);
    if (exp_res.top_priority !== act_res.top_priority)
      note_mismatch("top_priority", exp_res.top_priority, act_res.top_priority);
    if (exp_res.entry_count !== act_res.entry_count)
      note_mismatch("entry_count", exp_res.entry_count, act_res.entry_count);
  endtask

  always @(posedge clk) begin : watch
    spq_out_t exp_res;
    if (!rst_n) begin
      held_entries.delete();
      pending_results.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with none expected, expected none, got %h",
                   $time, out_item);
        end else begin
          exp_res = pending_results.pop_front();
          compare_result(exp_res, out_item);
        end
      end
      if (start && !busy)
        pending_results.push_back(serve_command(in_item));
    end
    outstanding = pending_results.size();
  end

endmodule

// File: tb/sv/tb_sorted_priority_queue_core.sv
// Testbench top for sorted_priority_queue_core: clock, reset, directed and
// random command stimulus with random idle cycles, and the verdict.
// Depends on spq_pkg, spq_checker and the core.
module tb_sorted_priority_queue_core import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned RANDOM_CMDS = 1200;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;
  localparam logic signed [31:0] PRIO_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] PRIO_MIN = 32'sh80000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  spq_in_t     in_item;
  logic        out_valid;
  spq_out_t    out_item;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count;

  sorted_priority_queue_core #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  spq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue_core regression: fail");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue_cmd(input spq_in_t cmd, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 17) begin
      start   <= 1'b0;
      in_item <= spq_in_t'(66'({$urandom, $urandom, $urandom}));
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic spq_in_t make_cmd(input logic [1:0] mode, input logic signed [31:0] data,
                                       input logic signed [31:0] prio);
    spq_in_t cmd;
    cmd.mode        = mode;
    cmd.data_in     = data;
    cmd.priority_in = prio;
    return cmd;
  endfunction

  function automatic logic signed [31:0] pick_priority();
    logic signed [31:0] prio;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: prio = $signed($urandom_range(0, 6)) - 3;
      5:             prio = $urandom_range(0, 1) ? PRIO_MAX : PRIO_MIN;
      default:       prio = $urandom;
    endcase
    return prio;
  endfunction

  function automatic logic [1:0] pick_mode(input int unsigned insert_pct);
    int unsigned roll;
    logic [1:0]  mode;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      mode = MODE_QUERY;
    else if (roll < 8)
      mode = MODE_SPARE;
    else if (roll < 8 + (insert_pct * 92) / 100)
      mode = MODE_INSERT;
    else
      mode = MODE_REMOVE;
    return mode;
  endfunction

  initial begin : stimulus
    int unsigned insert_pct;
    bit          may_idle;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty queue cases, then extremes, ties and a drain past empty
    issue_cmd(make_cmd(MODE_QUERY, 32'sd0, 32'sd0), 1'b1);
    issue_cmd(make_cmd(MODE_REMOVE, 32'sd5, 32'sd7), 1'b1);
    issue_cmd(make_cmd(MODE_SPARE, -32'sd1, -32'sd1), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sh7fffffff, 32'sd0), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sh80000000, 32'sd0), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, -32'sd1, PRIO_MAX), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sd0, PRIO_MIN), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sd1, -32'sd1), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sd3, 32'sd1), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sd2, PRIO_MAX), 1'b1);
    issue_cmd(make_cmd(MODE_INSERT, 32'sd4, PRIO_MIN), 1'b1);
    issue_cmd(make_cmd(MODE_QUERY, 32'sh55555555, 32'shaaaaaaaa), 1'b1);
    issue_cmd(make_cmd(MODE_SPARE, 32'shaaaaaaaa, 32'sh55555555), 1'b1);
    repeat (9) issue_cmd(make_cmd(MODE_REMOVE, 32'sd0, 32'sd0), 1'b1);

    // phases alternate between filling past full, draining past empty and churn
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      case ((n / 60) % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      may_idle = !(n >= 500 && n < 700);
      issue_cmd(make_cmd(pick_mode(insert_pct), $urandom, pick_priority()), may_idle);
    end
    start   <= 1'b0;
    in_item <= '0;

    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("sorted_priority_queue_core regression: pass");
    end else begin
      $display("sorted_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_core.sv
tb/sv/spq_checker.sv
tb/sv/tb_sorted_priority_queue_core.sv
